>>> rtl/core/plrap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrap_pkg
// Shared types, constants and per-byte helper functions for the pkt-line
// ref advertisement parser.
// ----------------------------------------------------------------------------
package plrap_pkg;

  localparam int MAX_REFS      = 256;
  localparam int NAME_BYTES    = 256;
  localparam int CAPS_BYTES    = 1024;
  localparam int OID_HEX_CHARS = 40;
  localparam int HOLD_DEPTH    = 4;

  localparam int RES_SLOTS = HOLD_DEPTH + 2;
  localparam int LAST_SLOT = HOLD_DEPTH + 1;
  localparam int BYTE_SLOT = HOLD_DEPTH;

  localparam int LEN_W  = 16;
  localparam int REF_W  = $clog2(MAX_REFS + 1);
  localparam int NAME_W = $clog2(NAME_BYTES);
  localparam int CAPS_W = $clog2(CAPS_BYTES);
  localparam int HCNT_W = $clog2(HOLD_DEPTH + 1);

  localparam logic [LEN_W-1:0]  HDR_LEN   = LEN_W'(4);
  localparam logic [LEN_W-1:0]  LEN_SAT   = '1;
  localparam logic [LEN_W-1:0]  OID_LEN   = LEN_W'(OID_HEX_CHARS);
  localparam logic [REF_W-1:0]  REFS_MAX  = REF_W'(MAX_REFS);
  localparam logic [NAME_W-1:0] NAME_MAX  = NAME_W'(NAME_BYTES - 1);
  localparam logic [CAPS_W-1:0] CAPS_MAX  = CAPS_W'(CAPS_BYTES - 1);
  localparam logic [HCNT_W-1:0] HOLD_FULL = HCNT_W'(HOLD_DEPTH);
  localparam logic [1:0]        HDR_LAST  = 2'd3;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_NUL  = 8'h00;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_e;

  typedef enum logic [2:0] {
    K_OID    = 3'd0,
    K_NAME   = 3'd1,
    K_CAPS   = 3'd2,
    K_COMMIT = 3'd3,
    K_ABORT  = 3'd4,
    K_STOP   = 3'd5
  } kind_e;

  typedef struct packed {
    logic skip;
    logic open;
    logic caps;
    logic badhex;
  } flags_t;

  typedef struct packed {
    phase_e                  phase;
    logic [1:0]              hdr_cnt;
    logic [LEN_W-1:0]        frame_len;
    logic [LEN_W-1:0]        pay_pos;
    logic [LEN_W-1:0]        cont_len;
    logic [3:0]              hi_nib;
    flags_t                  flags;
    logic [REF_W-1:0]        refs;
    logic [NAME_W-1:0]       name_cnt;
    logic [CAPS_W-1:0]       caps_cnt;
    logic [HOLD_DEPTH-1:0]   held_lf;   // held byte is LF when set, CR otherwise
    logic [HCNT_W-1:0]       held_cnt;
  } pst_t;

  typedef struct packed {
    logic       vld;
    kind_e      kind;
    logic [7:0] value;
  } res_t;

  typedef res_t [RES_SLOTS-1:0] batch_t;

  typedef struct packed {
    pst_t st;
    res_t res;
  } tc_t;

  function automatic res_t mk_res(kind_e k, logic [7:0] v);
    res_t r;
    r.vld   = 1'b1;
    r.kind  = k;
    r.value = v;
    return r;
  endfunction

  // 0..15 for a hex digit, 16 otherwise
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b inside {[8'h30:8'h39]}) begin
      v = 5'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      v = 5'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      v = 5'(b - 8'h37);
    end
    return v;
  endfunction

  function automatic logic [7:0] held_byte(logic is_lf);
    return is_lf ? CH_LF : CH_CR;
  endfunction

  function automatic tc_t take_content(pst_t st, logic [7:0] b);
    tc_t              r;
    logic [LEN_W-1:0] p;
    logic [4:0]       v;
    r.st  = st;
    r.res = '0;
    p     = st.cont_len;
    v     = hex_val(b);
    if (!st.flags.skip) begin
      r.st.flags.open = 1'b1;
      if (p != LEN_SAT) begin
        r.st.cont_len = p + LEN_W'(1);
      end
      if (p < OID_LEN) begin
        if (v[4]) begin
          r.res           = mk_res(K_ABORT, 8'h00);
          r.st.flags.skip = 1'b1;
          r.st.flags.open = 1'b0;
        end else if (p[0]) begin
          r.res = mk_res(K_OID, {st.hi_nib, v[3:0]});
        end else begin
          r.st.hi_nib = v[3:0];
        end
      end else if (p > OID_LEN) begin
        if (!st.flags.caps) begin
          if (b == CH_NUL) begin
            r.st.flags.caps = 1'b1;
          end else if (st.name_cnt < NAME_MAX) begin
            r.res         = mk_res(K_NAME, b);
            r.st.name_cnt = st.name_cnt + NAME_W'(1);
          end
        end else if (st.refs == '0 && st.caps_cnt < CAPS_MAX) begin
          r.res         = mk_res(K_CAPS, b);
          r.st.caps_cnt = st.caps_cnt + CAPS_W'(1);
        end
      end
    end
    return r;
  endfunction

  function automatic tc_t end_ref(pst_t st);
    tc_t r;
    r.st  = st;
    r.res = '0;
    if (st.flags.open) begin
      if (st.cont_len > OID_LEN) begin
        r.res = mk_res(K_COMMIT, 8'h00);
        if (st.refs < REFS_MAX) begin
          r.st.refs = st.refs + REF_W'(1);
        end
      end else begin
        r.res = mk_res(K_ABORT, 8'h00);
      end
      r.st.flags.open = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/plrap_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrap_step
// Parser state register and the per-byte step: header decode, CR/LF hold,
// ref line content and end-of-line handling. Emits at most one batch per beat.
// ----------------------------------------------------------------------------
module plrap_step
  import plrap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       ir_vld,
  input  logic [7:0] ir_byte,
  input  logic       ir_end,
  input  logic       bat_rdy,
  output logic       bat_vld,
  output batch_t     bat,
  output logic       step_take
);

  pst_t st;
  pst_t st_next;
  logic any_res;

  always_comb begin
    pst_t             s;
    tc_t              tc;
    logic [4:0]       hv;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             is_crlf;
    s       = st;
    bat     = '0;
    hv      = hex_val(ir_byte);
    len     = '0;
    last    = (st.pay_pos + LEN_W'(1)) == (st.frame_len - HDR_LEN);
    is_crlf = (ir_byte == CH_CR) || (ir_byte == CH_LF);
    case (st.phase)
      PH_HEADER: begin
        if (s.hdr_cnt == 2'd0) begin
          s.frame_len = '0;
          s.flags     = '0;
        end
        if (hv[4]) begin
          s.flags.badhex = 1'b1;
        end else begin
          s.frame_len = {s.frame_len[LEN_W-5:0], hv[3:0]};
        end
        if (s.hdr_cnt != HDR_LAST) begin
          s.hdr_cnt = s.hdr_cnt + 2'd1;
        end else begin
          s.hdr_cnt = 2'd0;
          len       = s.flags.badhex ? '0 : s.frame_len;
          s.flags   = '0;
          if (len == '0 || len == HDR_LEN) begin
            s.frame_len = '0;
          end else if (len < HDR_LEN || ir_end) begin
            bat[LAST_SLOT] = mk_res(K_STOP, 8'h00);
            s.phase        = PH_STOPPED;
          end else begin
            s.phase    = PH_PAYLOAD;
            s.pay_pos  = '0;
            s.cont_len = '0;
            s.name_cnt = '0;
            s.caps_cnt = '0;
            s.held_cnt = '0;
          end
        end
      end
      PH_PAYLOAD: begin
        if (ir_end && !last) begin
          if (s.flags.open) begin
            bat[BYTE_SLOT] = mk_res(K_ABORT, 8'h00);
          end
          bat[LAST_SLOT] = mk_res(K_STOP, 8'h00);
          s.phase        = PH_STOPPED;
        end else begin
          if (st.pay_pos == '0 && (ir_byte == CH_HASH || st.refs >= REFS_MAX)) begin
            s.flags.skip = 1'b1;
          end
          if (is_crlf) begin
            if (last) begin
              s.held_cnt = '0;
            end else if (st.held_cnt >= HOLD_FULL) begin
              // hold full: oldest byte goes out as content
              tc     = take_content(s, held_byte(st.held_lf[0]));
              s      = tc.st;
              bat[0] = tc.res;
              for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                s.held_lf[i] = st.held_lf[i+1];
              end
              s.held_lf[HOLD_DEPTH-1] = (ir_byte == CH_LF);
            end else begin
              for (int i = 0; i < HOLD_DEPTH; i++) begin
                if (HCNT_W'(i) == st.held_cnt) begin
                  s.held_lf[i] = (ir_byte == CH_LF);
                end
              end
              s.held_cnt = st.held_cnt + HCNT_W'(1);
            end
          end else begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
              if (HCNT_W'(i) < st.held_cnt) begin
                tc     = take_content(s, held_byte(st.held_lf[i]));
                s      = tc.st;
                bat[i] = tc.res;
              end
            end
            s.held_cnt     = '0;
            tc             = take_content(s, ir_byte);
            s              = tc.st;
            bat[BYTE_SLOT] = tc.res;
          end
          s.pay_pos = s.pay_pos + LEN_W'(1);
          if (last) begin
            s.held_cnt     = '0;
            tc             = end_ref(s);
            s              = tc.st;
            bat[LAST_SLOT] = tc.res;
            s.phase        = PH_HEADER;
            s.frame_len    = '0;
            s.flags        = '0;
          end
        end
      end
      default: ;
    endcase
    if (ir_end) begin
      s = '0;
    end
    st_next = s;
  end

  always_comb begin
    any_res = 1'b0;
    for (int i = 0; i < RES_SLOTS; i++) begin
      any_res = any_res | bat[i].vld;
    end
  end

  assign bat_vld   = ir_vld && any_res;
  assign step_take = ir_vld && (bat_rdy || !any_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_take) begin
      st <= st_next;
    end
  end

endmodule

>>> rtl/core/plrap_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrap_drain
// Result register: holds one batch of up to RES_SLOTS results and sends
// them out one beat at a time, lowest slot first.
// ----------------------------------------------------------------------------
module plrap_drain
  import plrap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       bat_vld,
  input  batch_t     bat,
  output logic       bat_rdy,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic       run_last
);

  logic [RES_SLOTS-1:0] mask;
  logic [RES_SLOTS-1:0] mask_next;
  logic [RES_SLOTS-1:0] in_mask;
  logic [RES_SLOTS-1:0] pick;
  logic                 single;
  batch_t               slots;

  always_comb begin
    for (int i = 0; i < RES_SLOTS; i++) begin
      in_mask[i] = bat[i].vld;
    end
  end

  assign pick         = mask & (~mask + RES_SLOTS'(1));
  assign single       = (mask & (mask - RES_SLOTS'(1))) == '0;
  assign result_valid = |mask;
  assign run_last     = single;
  assign bat_rdy      = (mask == '0) || (result_ready && single);

  always_comb begin
    kind  = '0;
    value = '0;
    for (int i = 0; i < RES_SLOTS; i++) begin
      if (pick[i]) begin
        kind  = slots[i].kind;
        value = slots[i].value;
      end
    end
  end

  always_comb begin
    mask_next = mask;
    if (bat_vld && bat_rdy) begin
      mask_next = in_mask;
    end else if (result_valid && result_ready) begin
      mask_next = mask & ~pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (bat_vld && bat_rdy) begin
      slots <= bat;
    end
  end

endmodule

>>> rtl/core/pkt_line_ref_advert_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkt_line_ref_advert_parser
// A byte goes through the input register, the step and the result register.
// Throughput: one body byte per cycle while results are taken; a byte's
//   results hold the result register until the single result port takes
//   them all. Bytes that make no result do not wait for the result register.
// Reset: synchronous, clears parser state and both registers; a byte with
//   body_end also returns the parser to its reset state.
// ----------------------------------------------------------------------------
module pkt_line_ref_advert_parser
  import plrap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       body_valid,
  output logic       body_ready,
  input  logic [7:0] body_byte,
  input  logic       body_end,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic       run_last
);

  logic       ir_vld;
  logic       ir_vld_next;
  logic [7:0] ir_byte;
  logic       ir_end;
  logic       step_take;
  logic       bat_vld;
  logic       bat_rdy;
  batch_t     bat;

  assign body_ready = !ir_vld || step_take;

  always_comb begin
    ir_vld_next = ir_vld;
    if (body_valid && body_ready) begin
      ir_vld_next = 1'b1;
    end else if (step_take) begin
      ir_vld_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_vld <= 1'b0;
    end else begin
      ir_vld <= ir_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (body_valid && body_ready) begin
      ir_byte <= body_byte;
      ir_end  <= body_end;
    end
  end

  plrap_step u_step (
    .clk       (clk),
    .rst       (rst),
    .ir_vld    (ir_vld),
    .ir_byte   (ir_byte),
    .ir_end    (ir_end),
    .bat_rdy   (bat_rdy),
    .bat_vld   (bat_vld),
    .bat       (bat),
    .step_take (step_take)
  );

  plrap_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .bat_vld      (bat_vld),
    .bat          (bat),
    .bat_rdy      (bat_rdy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .value        (value),
    .run_last     (run_last)
  );

endmodule

>>> rtl/core/plrap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrap_checker
// Port-level checks for the pkt-line ref advertisement parser.
// ----------------------------------------------------------------------------
module plrap_checker
  import plrap_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       body_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [2:0] kind,
  input logic [7:0] value,
  input logic       run_last
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && body_ready)
    else $error("not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(kind) && $stable(value) && $stable(run_last))
    else $error("stalled result beat changed");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == K_COMMIT || kind == K_ABORT || kind == K_STOP)
      |-> value == 8'h00)
    else $error("marker beat carries data");

  a_end_marker_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == K_COMMIT || kind == K_STOP) |-> run_last)
    else $error("commit or stop not last of its byte");

endmodule

bind pkt_line_ref_advert_parser plrap_checker u_plrap_checker (
  .clk          (clk),
  .rst          (rst),
  .body_ready   (body_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .kind         (kind),
  .value        (value),
  .run_last     (run_last)
);

>>> test/pkt_line_ref_advert_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkt_line_ref_advert_parser_test
// Self-checking bench for the pkt-line ref advertisement parser. Header corner
// cases come first, then random bodies of ref, comment, flush and broken
// frames. Both channels stall at random. Every result beat is checked against
// an in-bench model of the parser.
// ----------------------------------------------------------------------------
module pkt_line_ref_advert_parser_test;
  import plrap_pkg::*;

  localparam int STALL_MAX  = 13;
  localparam int HOLD_CYC   = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYC   = 20;
  localparam int RAND_BEATS = 290;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic [3:0] gap;
    logic       drain;
  } body_beat_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       last;
  } advert_res_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       body_valid   = 1'b0;
  logic       body_ready;
  logic [7:0] body_byte    = 8'h00;
  logic       body_end     = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] value;
  logic       run_last;

  logic body_took = 1'b0;
  logic res_took  = 1'b0;
  bit   bad       = 1'b0;

  pkt_line_ref_advert_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .body_valid   (body_valid),
    .body_ready   (body_ready),
    .body_byte    (body_byte),
    .body_end     (body_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .value        (value),
    .run_last     (run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  phase_e            adv_phase;
  logic [1:0]        adv_digits;
  logic [LEN_W-1:0]  adv_flen;
  logic [LEN_W-1:0]  adv_pos;
  logic [LEN_W-1:0]  adv_clen;
  logic [3:0]        adv_hi;
  logic              adv_skip;
  logic              adv_open;
  logic              adv_caps;
  logic              adv_badhex;
  logic [REF_W-1:0]  adv_refs;
  logic [NAME_W-1:0] adv_names;
  logic [CAPS_W-1:0] adv_capn;
  logic [7:0]        adv_held [HOLD_DEPTH];
  int                adv_held_n;

  advert_res_t step_q[$];
  advert_res_t awaited_q[$];

  function automatic logic [4:0] hex_digit(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 8'd10);
    if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 8'd10);
    return 5'h10;
  endfunction

  function automatic void emit_res(kind_e k, logic [7:0] v);
    advert_res_t r;
    if (step_q.size() < RES_SLOTS) begin
      r.kind  = k;
      r.value = v;
      r.last  = 1'b0;
      step_q.push_back(r);
    end
  endfunction

  function automatic void clear_flags();
    adv_skip   = 1'b0;
    adv_open   = 1'b0;
    adv_caps   = 1'b0;
    adv_badhex = 1'b0;
  endfunction

  function automatic void clear_parser();
    int i;
    adv_phase  = PH_HEADER;
    adv_digits = '0;
    adv_flen   = '0;
    adv_pos    = '0;
    adv_clen   = '0;
    adv_hi     = '0;
    adv_refs   = '0;
    adv_names  = '0;
    adv_capn   = '0;
    adv_held_n = 0;
    clear_flags();
    for (i = 0; i < HOLD_DEPTH; i++) adv_held[i] = 8'h00;
  endfunction

  function automatic void line_content(logic [7:0] b);
    logic [LEN_W-1:0] p;
    logic [4:0]       d;
    if (adv_skip) return;
    adv_open = 1'b1;
    p = adv_clen;
    if (adv_clen != LEN_SAT) adv_clen = adv_clen + 1'b1;
    d = hex_digit(b);
    if (p < OID_LEN) begin
      if (d[4]) begin
        emit_res(K_ABORT, 8'h00);
        adv_skip = 1'b1;
        adv_open = 1'b0;
      end else if (p[0]) begin
        emit_res(K_OID, {adv_hi, d[3:0]});
      end else begin
        adv_hi = d[3:0];
      end
    end else if (p > OID_LEN) begin
      if (!adv_caps) begin
        if (b == CH_NUL) begin
          adv_caps = 1'b1;
        end else if (adv_names < NAME_MAX) begin
          emit_res(K_NAME, b);
          adv_names = adv_names + 1'b1;
        end
      end else if (adv_refs == '0 && adv_capn < CAPS_MAX) begin
        emit_res(K_CAPS, b);
        adv_capn = adv_capn + 1'b1;
      end
    end
  endfunction

  function automatic void close_line();
    if (!adv_open) return;
    if (adv_clen > OID_LEN) begin
      emit_res(K_COMMIT, 8'h00);
      if (adv_refs < REFS_MAX) adv_refs = adv_refs + 1'b1;
    end else begin
      emit_res(K_ABORT, 8'h00);
    end
    adv_open = 1'b0;
  endfunction

  function automatic void header_in(logic [7:0] b, logic fin);
    logic [4:0]       d;
    logic [LEN_W-1:0] len;
    if (adv_digits == 2'd0) begin
      adv_flen = '0;
      clear_flags();
    end
    d = hex_digit(b);
    if (d[4]) begin
      adv_badhex = 1'b1;
    end else begin
      adv_flen = {adv_flen[LEN_W-5:0], d[3:0]};
    end
    if (adv_digits != HDR_LAST) begin
      adv_digits = adv_digits + 1'b1;
      return;
    end
    adv_digits = '0;
    len = adv_badhex ? '0 : adv_flen;
    clear_flags();
    if (len == '0 || len == HDR_LEN) begin
      adv_flen = '0;
    end else if (len < HDR_LEN || fin) begin
      emit_res(K_STOP, 8'h00);
      adv_phase = PH_STOPPED;
    end else begin
      adv_phase  = PH_PAYLOAD;
      adv_pos    = '0;
      adv_clen   = '0;
      adv_names  = '0;
      adv_capn   = '0;
      adv_held_n = 0;
    end
  endfunction

  function automatic void payload_in(logic [7:0] b, logic fin);
    logic last;
    int   i;
    last = (int'(adv_pos) + 1 == int'(adv_flen) - 4);
    if (fin && !last) begin
      if (adv_open) emit_res(K_ABORT, 8'h00);
      emit_res(K_STOP, 8'h00);
      adv_phase = PH_STOPPED;
      return;
    end
    if (adv_pos == '0 && (b == CH_HASH || adv_refs >= REFS_MAX)) adv_skip = 1'b1;
    if (b == CH_CR || b == CH_LF) begin
      if (last) begin
        adv_held_n = 0;
      end else if (adv_held_n >= HOLD_DEPTH) begin
        // hold is full: the oldest CR/LF becomes content
        line_content(adv_held[0]);
        for (i = 1; i < HOLD_DEPTH; i++) adv_held[i-1] = adv_held[i];
        adv_held[HOLD_DEPTH-1] = b;
      end else begin
        adv_held[adv_held_n] = b;
        adv_held_n++;
      end
    end else begin
      for (i = 0; i < adv_held_n; i++) line_content(adv_held[i]);
      adv_held_n = 0;
      line_content(b);
    end
    adv_pos = adv_pos + 1'b1;
    if (last) begin
      adv_held_n = 0;
      close_line();
      adv_phase = PH_HEADER;
      adv_flen  = '0;
      clear_flags();
    end
  endfunction

  function automatic void parse_beat(logic [7:0] b, logic fin);
    advert_res_t r;
    step_q.delete();
    if (adv_phase == PH_HEADER) begin
      header_in(b, fin);
    end else if (adv_phase == PH_PAYLOAD) begin
      payload_in(b, fin);
    end
    if (fin) clear_parser();
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    while (step_q.size() > 0) awaited_q.push_back(step_q.pop_front());
  endfunction

  function automatic void check_result();
    advert_res_t want;
    if (awaited_q.size() == 0) begin
      $display("%0t: unexpected result beat kind=%0d value=%02h run_last=%0b",
               $time, kind, value, run_last);
      bad = 1'b1;
      return;
    end
    want = awaited_q.pop_front();
    if (kind != want.kind) begin
      $display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
      bad = 1'b1;
    end
    if (value != want.value) begin
      $display("%0t: value expected %02h, got %02h", $time, want.value, value);
      bad = 1'b1;
    end
    if (run_last != want.last) begin
      $display("%0t: run_last expected %0b, got %0b", $time, want.last, run_last);
      bad = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  body_beat_t beat_q[$];
  logic [7:0] line_q[$];
  bit         send_burst = 1'b0;
  bit         drain_next = 1'b0;

  function automatic void push_beat(logic [7:0] d);
    body_beat_t bt;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    bt.data  = d;
    bt.fin   = 1'b0;
    bt.gap   = send_burst ? 4'd0 : 4'($urandom_range(0, STALL_MAX));
    bt.drain = drain_next;
    drain_next = 1'b0;
    beat_q.push_back(bt);
  endfunction

  function automatic void end_body();
    body_beat_t bt;
    bt = beat_q.pop_back();
    bt.fin = 1'b1;
    beat_q.push_back(bt);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    logic [4:0] d;
    b = 8'h00;
    d = 5'd0;
    while (!d[4]) begin
      b = 8'($urandom);
      d = hex_digit(b);
    end
    return b;
  endfunction

  function automatic logic [7:0] crlf();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  function automatic void push_header(int len);
    int i;
    for (i = 3; i >= 0; i--) push_beat(hex_char(4'(len >> (4 * i))));
  endfunction

  // cut: the body ends on a random payload byte of this frame
  function automatic void push_frame(bit cut);
    int i;
    int stop_at;
    cut = cut && line_q.size() > 0;
    push_header(line_q.size() + 4);
    stop_at = cut ? $urandom_range(0, line_q.size() - 1) : line_q.size() - 1;
    for (i = 0; i <= stop_at; i++) push_beat(line_q[i]);
    if (cut) end_body();
  endfunction

  function automatic void make_ref(int name_n, int caps_n, bit plain);
    int v, i, k;
    line_q.delete();
    v = plain ? 9 : $urandom_range(0, 9);
    for (i = 0; i < OID_HEX_CHARS; i++) line_q.push_back(hex_char(4'($urandom)));
    if (v == 0) line_q[$urandom_range(0, OID_HEX_CHARS - 1)] = non_hex();
    line_q.push_back(8'($urandom));
    for (i = 0; i < name_n; i++) line_q.push_back(8'($urandom_range(1, 255)));
    if (v == 2) begin
      k = $urandom_range(HOLD_DEPTH + 1, HOLD_DEPTH + 3);
      for (i = 0; i < k; i++) line_q.push_back(crlf());
      line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end
    if (caps_n > 0) begin
      line_q.push_back(CH_NUL);
      for (i = 0; i < caps_n; i++) line_q.push_back(8'($urandom));
    end
    if (v == 3) begin
      // full hold released by the closing byte: the busiest beat
      for (i = 0; i < HOLD_DEPTH; i++) line_q.push_back(crlf());
      line_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end else begin
      k = $urandom_range(0, HOLD_DEPTH + 2);
      for (i = 0; i < k; i++) line_q.push_back(crlf());
    end
    if (v == 1) begin
      k = $urandom_range(1, OID_HEX_CHARS + 1);
      while (line_q.size() > k) void'(line_q.pop_back());
    end
  endfunction

  function automatic void make_body();
    int nf, f, r, n, i, ending;
    bit cut;
    if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
    nf     = $urandom_range(1, 4);
    ending = $urandom_range(0, 9);
    for (f = 0; f < nf; f++) begin
      r   = $urandom_range(0, 99);
      cut = (f == nf - 1) && (ending == 6 || ending == 7);
      line_q.delete();
      if (r < 60) begin
        make_ref($urandom_range(0, 12), $urandom_range(0, 1) ? $urandom_range(1, 8) : 0, 1'b0);
        push_frame(cut);
      end else if (r < 68) begin
        line_q.push_back(CH_HASH);
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++) line_q.push_back(8'($urandom));
        push_frame(cut);
      end else if (r < 73) begin
        push_header(0);
      end else if (r < 77) begin
        n = $urandom_range(0, 3);
        for (i = 0; i < 4; i++) push_beat(i == n ? non_hex() : hex_char(4'($urandom)));
      end else if (r < 81) begin
        push_header(4);
      end else if (r < 85) begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) line_q.push_back(crlf());
        push_frame(cut);
      end else if (r < 89) begin
        push_header($urandom_range(1, 3));
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) push_beat(8'($urandom));
        end_body();
        return;
      end else begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) line_q.push_back(8'($urandom));
        push_frame(cut);
      end
    end
    if (ending == 8) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) push_beat(8'($urandom));
    end else if (ending == 9) begin
      push_header($urandom_range(5, 65535));
    end
    end_body();
  endfunction

  function automatic void build_stimulus();
    int i, mark;
    // flush, empty frame, bad digit flush
    for (i = 0; i < 4; i++) push_beat(8'h30);
    push_beat(8'h30); push_beat(8'h30); push_beat(8'h30); push_beat(8'h34);
    push_beat(8'h30); push_beat(8'h30); push_beat(8'h46); push_beat(8'hFF);
    // length two stops, rest ignored up to body end
    push_beat(8'h30); push_beat(8'h30); push_beat(8'h30); push_beat(8'h32);
    push_beat(8'h00); push_beat(8'hFF);
    end_body();
    // partial header at body end
    push_beat(8'h30); push_beat(8'h61);
    end_body();
    // long header cut by body end
    push_beat(8'h66); push_beat(8'h66); push_beat(8'h46); push_beat(8'h66);
    end_body();

    drain_next = 1'b1;
    mark = beat_q.size();
    while (beat_q.size() < mark + RAND_BEATS) make_body();
  endfunction

  // --------------------------------------------------------------------------
  // Driver, receiver, monitor
  // --------------------------------------------------------------------------
  body_beat_t cur_beat;
  bit         beat_loaded = 1'b0;
  int         beat_wait   = 0;

  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = body_valid;
    if (!rst && !(body_valid && !body_took)) begin
      if (!beat_loaded && beat_q.size() > 0 &&
          !(beat_q[0].drain && awaited_q.size() > 0)) begin
        cur_beat    = beat_q.pop_front();
        beat_loaded = 1'b1;
        beat_wait   = cur_beat.gap;
      end
      nxt_valid = 1'b0;
      if (beat_loaded) begin
        if (beat_wait == 0) begin
          body_byte   <= cur_beat.data;
          body_end    <= cur_beat.fin;
          nxt_valid   = 1'b1;
          beat_loaded = 1'b0;
        end else begin
          beat_wait--;
        end
      end
    end
    body_valid <= nxt_valid;
  end

  int rx_wait  = 0;
  int rx_seen  = 0;
  bit rx_burst = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (res_took) begin
        rx_seen++;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, STALL_MAX);
        // long back-pressure so the block fills and stalls its input
        if (rx_seen == 30 || rx_seen == 90) rx_wait = HOLD_CYC;
      end
      if (rx_wait > 0) begin
        result_ready <= 1'b0;
        rx_wait--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    body_took <= !rst && body_valid && body_ready;
    res_took  <= !rst && result_valid && result_ready;
    if (!rst && result_valid && result_ready) check_result();
    if (!rst && body_valid && body_ready) parse_beat(body_byte, body_end);
  end

  int idle_cyc = 0;

  always @(posedge clk) begin
    if (rst || (body_valid && body_ready) || (result_valid && result_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("[pkt_line_ref_advert_parser] ERROR");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    clear_parser();
    build_stimulus();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (beat_q.size() > 0 || beat_loaded || body_valid || awaited_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYC) @(posedge clk);
    if (!bad && awaited_q.size() == 0) begin
      $display("[pkt_line_ref_advert_parser] OK");
    end else begin
      $display("[pkt_line_ref_advert_parser] ERROR");
    end
    $finish;
  end

endmodule
